// ===== src/tor_pkg.sv =====
package tor_pkg;

    localparam logic [7:0] TN_IAC     = 8'd255;
    localparam logic [7:0] TN_WILL    = 8'd251;
    localparam logic [7:0] TN_WONT    = 8'd252;
    localparam logic [7:0] TN_DO      = 8'd253;
    localparam logic [7:0] TN_DONT    = 8'd254;
    localparam logic [7:0] TN_OPT_SGA = 8'd3;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam int CAP_W = 17;
    localparam int POS_W = 16;
    localparam logic [CAP_W-1:0] CAP_MAX   = 17'd65536;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'd2048;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int PADDR_W = 3;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_IAC  = 2'd1,
        PH_VERB = 2'd2
    } parse_phase_t;

    typedef enum logic [1:0] {
        VERB_WILL = 2'd0,
        VERB_WONT = 2'd1,
        VERB_DO   = 2'd2,
        VERB_DONT = 2'd3
    } verb_t;

    typedef enum logic [1:0] {
        BEAT_IAC    = 2'd0,
        BEAT_VERB   = 2'd1,
        BEAT_OPTION = 2'd2
    } beat_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       value;
        logic [POS_W-1:0] position;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic             is_reply;
        logic [7:0]       value;
        logic [POS_W-1:0] position;
        logic [7:0]       reply_verb;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== src/tor_front.sv =====
module tor_front
    import tor_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_word,
    input  logic [CAP_W-1:0]     capacity,
    input  queue_status_t        queue_status,
    output logic                 push,
    output op_t                  push_op
);

    parse_phase_t      phase_reg, phase_next;
    verb_t             verb_reg, verb_next;
    logic [CAP_W-1:0]  space_reg, space_next;
    logic [POS_W-1:0]  windex_reg, windex_next;
    logic              accept;
    logic [CAP_W-1:0]  capped;
    logic [7:0]        b;
    logic              sga;
    logic [7:0]        reply;

    assign in_stall = queue_status.full;
    assign accept   = in_valid && !queue_status.full;
    assign capped   = (capacity > CAP_MAX) ? CAP_MAX : capacity;
    assign b        = in_word.rx_byte;
    assign sga      = (b == TN_OPT_SGA);

    always_comb
    begin
        case (verb_reg)
            VERB_WONT: reply = TN_DONT;
            VERB_DONT: reply = TN_WONT;
            VERB_DO:   reply = sga ? TN_WILL : TN_WONT;
            default:   reply = sga ? TN_DO : TN_DONT;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        verb_next   = verb_reg;
        space_next  = space_reg;
        windex_next = windex_reg;
        push        = 1'b0;
        push_op     = '{is_reply: KIND_DATA, value: b, position: windex_reg, reply_verb: reply};
        if (accept)
        begin
            if (in_word.command == CMD_RESTART)
            begin
                space_next  = capped;
                windex_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_IAC:
                    begin
                        phase_next = PH_DATA;
                        if (b == TN_IAC)
                        begin
                            push = (space_reg != '0);
                        end
                        else if (b >= TN_WILL && b <= TN_DONT)
                        begin
                            verb_next  = verb_t'(b[1:0] + 2'd1);
                            phase_next = PH_VERB;
                        end
                    end
                    PH_VERB:
                    begin
                        phase_next       = PH_DATA;
                        push             = 1'b1;
                        push_op.is_reply = KIND_REPLY;
                        push_op.position = '0;
                    end
                    default:
                    begin
                        if (b == TN_IAC)
                        begin
                            phase_next = PH_IAC;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            push       = (space_reg != '0);
                        end
                    end
                endcase
                if (push && !push_op.is_reply)
                begin
                    windex_next = windex_reg + 1'b1;
                    space_next  = space_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DATA;
            verb_reg   <= VERB_WILL;
            space_reg  <= CAP_RESET;
            windex_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            verb_reg   <= verb_next;
            space_reg  <= space_next;
            windex_reg <= windex_next;
        end
    end

endmodule

// ===== src/tor_queue.sv =====
module tor_queue
    import tor_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  op_t            push_op,
    input  logic           pop,
    output op_t            head_op,
    output queue_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_op      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/tor_back.sv =====
module tor_back
    import tor_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  op_t            head_op,
    input  queue_status_t  queue_status,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output out_word_t      out_word
);

    beat_t      beat_reg, beat_next;
    logic       valid_reg, valid_next;
    out_word_t  word_reg, word_next;
    logic       load;

    assign load      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        word_next  = word_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !queue_status.empty;
            if (!queue_status.empty)
            begin
                if (!head_op.is_reply)
                begin
                    word_next = '{kind: KIND_DATA, value: head_op.value,
                                  position: head_op.position, last: 1'b1};
                    pop       = 1'b1;
                end
                else
                begin
                    word_next.kind     = KIND_REPLY;
                    word_next.position = '0;
                    word_next.last     = 1'b0;
                    case (beat_reg)
                        BEAT_IAC:
                        begin
                            word_next.value = TN_IAC;
                            beat_next       = BEAT_VERB;
                        end
                        BEAT_VERB:
                        begin
                            word_next.value = head_op.reply_verb;
                            beat_next       = BEAT_OPTION;
                        end
                        default:
                        begin
                            word_next.value = head_op.value;
                            word_next.last  = 1'b1;
                            beat_next       = BEAT_IAC;
                            pop             = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg  <= BEAT_IAC;
            valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ===== src/telnet_option_refuser.sv =====
// Telnet receive-side option refuser.
// Input channel (in_valid / in_stall / in_word): one received byte or a restart
// command per word. Output channel (out_valid / out_stall / out_word): data bytes
// with their buffer position, or three-byte IAC replies, last set on the final
// word caused by an input word.
// An accepted word is written into the op queue, then loaded into the output register.
// Throughput: one input word per cycle while the output side keeps up; a reply
// occupies the output register for three output words, and the op queue between the
// parser and the output sequencer (QUEUE_DEPTH entries) absorbs that until full.
// in_stall rises only when the op queue is full.
// Stall on the output holds out_word; the queue keeps filling, then stalls input.
// Reset: parser in data phase, buffer count at zero with 2048 bytes of space,
// capacity register at 2048, queue empty, no output word valid.
// APB: capacity register at address 0; a new capacity applies at the next restart.
module telnet_option_refuser
    import tor_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_word_t            in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output out_word_t           out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [CAP_W-1:0]  capacity_reg;
    logic              cfg_write;
    logic              push;
    logic              pop;
    op_t               push_op;
    op_t               head_op;
    queue_status_t     queue_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    tor_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .capacity     (capacity_reg),
        .queue_status (queue_status),
        .push         (push),
        .push_op      (push_op)
    );

    tor_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (queue_status)
    );

    tor_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_op      (head_op),
        .queue_status (queue_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_status.full)
        else $error("op pushed into full queue");

    a_data_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.kind == KIND_DATA |-> out_word.last)
        else $error("data word without last");

    a_reply_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.kind == KIND_REPLY |-> out_word.position == '0)
        else $error("reply word with nonzero position");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_status.empty)
        else $error("pop from empty queue");

endmodule
